>>> sv/mi4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_pkg: shared types and constants for the 4x4 matrix inverse
// Item formats, controller states, datapath command and status groups.
// ----------------------------------------------------------------------------
package mi4_pkg;

    localparam int ELEM_W    = 32;
    localparam int FRAC_BITS = 16;
    // cofactors need about 99 bits, the determinant about 133
    localparam int ACC_W     = 136;
    // quotient bits: 32 result bits plus two for overflow detection
    localparam int Q_W       = 34;
    localparam int DIV_W     = ACC_W + 2 * FRAC_BITS + Q_W + 2;
    localparam int MCNT_W    = $clog2(ELEM_W);
    localparam int DCNT_W    = $clog2(Q_W);

    localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem0;
        logic signed [ELEM_W-1:0] elem1;
        logic signed [ELEM_W-1:0] elem2;
        logic signed [ELEM_W-1:0] elem3;
    } mi4_in_t;

    typedef struct packed {
        logic [1:0]               row_number;
        logic signed [ELEM_W-1:0] out0;
        logic signed [ELEM_W-1:0] out1;
        logic signed [ELEM_W-1:0] out2;
        logic signed [ELEM_W-1:0] out3;
        logic                     singular;
        logic                     saturated;
        logic                     last_row;
    } mi4_out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR_C,
        ST_CLR_M,
        ST_M1_X,
        ST_M1_Y,
        ST_M1_MUL,
        ST_M1_ACC,
        ST_M2_X,
        ST_M2_Y,
        ST_M2_MUL,
        ST_M2_ACC,
        ST_T_X,
        ST_T_Y,
        ST_T_MUL,
        ST_T_ACC,
        ST_STORE,
        ST_DET_CLR,
        ST_D_X,
        ST_D_Y,
        ST_D_MUL,
        ST_D_ACC,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_END,
        ST_EMIT
    } mi4_state_t;

    typedef struct packed {
        logic       wr_row;
        logic [1:0] wr_idx;
        logic       ld_x_mat;
        logic       ld_x_m;
        logic       ld_x_cof;
        logic       ld_y;
        logic [3:0] mat_addr;
        logic [3:0] cof_addr;
        logic       mul_step;
        logic       clr_m;
        logic       clr_c;
        logic       clr_d;
        logic       acc_m;
        logic       acc_c;
        logic       acc_d;
        logic       acc_sub;
        logic       st_cof;
        logic       st_neg;
        logic       div_load;
        logic       div_step;
        logic       div_end;
        logic [1:0] out_col;
        logic       emit;
        logic [1:0] out_row;
    } mi4_cmd_t;

    typedef struct packed {
        logic mul_last;
        logic div_last;
        logic singular;
    } mi4_stat_t;

    // index of the k-th row or column that remains once index skip is removed
    function automatic logic [1:0] mi4_keep(input logic [1:0] k, input logic [1:0] skip);
        logic [1:0] res;
        res = (k < skip) ? k : 2'(k + 2'd1);
        return res;
    endfunction

endpackage

>>> sv/mi4_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_datapath: storage and arithmetic of the 4x4 matrix inverse
// Matrix store, shift-add multiplier, accumulators, cofactor store,
// restoring divider and the result register.
// ----------------------------------------------------------------------------
module mi4_datapath
    import mi4_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mi4_in_t   item,
    input  mi4_cmd_t  cmd,
    output mi4_stat_t stat,
    output mi4_out_t  result,
    output logic      valid
);

    logic [ELEM_W-1:0]       mat_reg [16];
    logic signed [ACC_W-1:0] cof_reg [16];
    logic signed [ACC_W-1:0] x_reg;
    logic signed [ACC_W-1:0] p_reg;
    logic signed [ACC_W-1:0] m_reg;
    logic signed [ACC_W-1:0] c_reg;
    logic signed [ACC_W-1:0] d_reg;
    logic [ELEM_W-1:0]       y_reg;
    logic [MCNT_W-1:0]       mcnt_reg;
    logic [DIV_W-1:0]        r_reg;
    logic [DIV_W-1:0]        ds_reg;
    logic [Q_W-1:0]          q_reg;
    logic [DCNT_W-1:0]       dcnt_reg;
    logic                    neg_reg;
    logic [ELEM_W-1:0]       col_reg [4];
    logic                    sat_reg;
    mi4_out_t                result_reg;
    logic                    valid_reg;

    logic [ELEM_W-1:0]       rd;
    logic signed [ACC_W-1:0] rd_ext;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] cof_rd;
    logic [ACC_W-1:0]        abs_num;
    logic [ACC_W-1:0]        abs_det;
    logic                    ge;
    logic [ELEM_W-1:0]       qv;
    logic [ELEM_W-1:0]       val;
    logic                    clip;

    // element and cofactor reads
    assign rd     = mat_reg[cmd.mat_addr];
    assign rd_ext = {{(ACC_W-ELEM_W){rd[ELEM_W-1]}}, rd};
    assign cof_rd = cof_reg[cmd.cof_addr];

    // multiplier step: the sign bit of y carries negative weight
    always_comb
    begin
        if (y_reg[ELEM_W-1])
        begin
            addend = (mcnt_reg == '0) ? -x_reg : x_reg;
        end
        else
        begin
            addend = '0;
        end
    end

    // divider operands
    assign abs_num = cof_rd[ACC_W-1] ? -cof_rd : cof_rd;
    assign abs_det = d_reg[ACC_W-1] ? -d_reg : d_reg;
    assign ge      = (r_reg >= ds_reg);

    // rounding already folded in, so only saturation remains
    always_comb
    begin
        qv   = q_reg[ELEM_W-1:0];
        val  = '0;
        clip = 1'b0;
        if (stat.singular)
        begin
            val = '0;
        end
        else if (q_reg[Q_W-1] || q_reg[Q_W-2])
        begin
            clip = 1'b1;
            val  = neg_reg ? SAT_MIN : SAT_MAX;
        end
        else if (neg_reg)
        begin
            if (qv > SAT_MIN)
            begin
                clip = 1'b1;
                val  = SAT_MIN;
            end
            else
            begin
                val = -qv;
            end
        end
        else if (qv > SAT_MAX)
        begin
            clip = 1'b1;
            val  = SAT_MAX;
        end
        else
        begin
            val = qv;
        end
    end

    assign stat.mul_last = (mcnt_reg == MCNT_W'(ELEM_W - 1));
    assign stat.div_last = (dcnt_reg == DCNT_W'(Q_W - 1));
    assign stat.singular = (d_reg == '0);

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.wr_row)
        begin
            mat_reg[{cmd.wr_idx, 2'd0}] <= item.elem0;
            mat_reg[{cmd.wr_idx, 2'd1}] <= item.elem1;
            mat_reg[{cmd.wr_idx, 2'd2}] <= item.elem2;
            mat_reg[{cmd.wr_idx, 2'd3}] <= item.elem3;
        end
        if (cmd.ld_x_mat)
        begin
            x_reg <= rd_ext;
        end
        if (cmd.ld_x_m)
        begin
            x_reg <= m_reg;
        end
        if (cmd.ld_x_cof)
        begin
            x_reg <= cof_rd;
        end
        if (cmd.ld_y)
        begin
            y_reg    <= rd;
            p_reg    <= '0;
            mcnt_reg <= '0;
        end
        if (cmd.mul_step)
        begin
            p_reg    <= (p_reg <<< 1) + addend;
            y_reg    <= {y_reg[ELEM_W-2:0], 1'b0};
            mcnt_reg <= MCNT_W'(mcnt_reg + 1'b1);
        end
        if (cmd.clr_m)
        begin
            m_reg <= '0;
        end
        if (cmd.clr_c)
        begin
            c_reg <= '0;
        end
        if (cmd.clr_d)
        begin
            d_reg <= '0;
        end
        if (cmd.acc_m)
        begin
            m_reg <= cmd.acc_sub ? m_reg - p_reg : m_reg + p_reg;
        end
        if (cmd.acc_c)
        begin
            c_reg <= cmd.acc_sub ? c_reg - p_reg : c_reg + p_reg;
        end
        if (cmd.acc_d)
        begin
            d_reg <= cmd.acc_sub ? d_reg - p_reg : d_reg + p_reg;
        end
        if (cmd.st_cof)
        begin
            cof_reg[cmd.cof_addr] <= cmd.st_neg ? -c_reg : c_reg;
        end
        if (cmd.div_load)
        begin
            r_reg    <= (DIV_W'(abs_num) << (2 * FRAC_BITS + 1)) + DIV_W'(abs_det);
            ds_reg   <= DIV_W'(abs_det) << Q_W;
            q_reg    <= '0;
            dcnt_reg <= '0;
            neg_reg  <= cof_rd[ACC_W-1] ^ d_reg[ACC_W-1];
        end
        if (cmd.div_step)
        begin
            if (ge)
            begin
                r_reg <= r_reg - ds_reg;
            end
            q_reg    <= {q_reg[Q_W-2:0], ge};
            ds_reg   <= ds_reg >> 1;
            dcnt_reg <= DCNT_W'(dcnt_reg + 1'b1);
        end
        if (cmd.div_end)
        begin
            col_reg[cmd.out_col] <= val;
        end
        if (cmd.emit)
        begin
            result_reg.row_number <= cmd.out_row;
            result_reg.out0       <= col_reg[0];
            result_reg.out1       <= col_reg[1];
            result_reg.out2       <= col_reg[2];
            result_reg.out3       <= col_reg[3];
            result_reg.singular   <= stat.singular;
            result_reg.saturated  <= sat_reg;
            result_reg.last_row   <= (cmd.out_row == 2'd3);
        end
    end

    // row clip flag and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            if (cmd.emit)
            begin
                sat_reg <= 1'b0;
            end
            else if (cmd.div_end)
            begin
                sat_reg <= sat_reg | clip;
            end
        end
    end

    assign result = result_reg;
    assign valid  = valid_reg;

endmodule

>>> sv/mi4_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_ctrl: sequencer of the 4x4 matrix inverse
// Counts incoming rows, then steps through the cofactors, the determinant
// and the sixteen divisions, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module mi4_ctrl
    import mi4_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  mi4_stat_t stat,
    output mi4_cmd_t  cmd,
    output logic      busy
);

    mi4_state_t state_reg, state_next;
    logic [3:0] cidx_reg, cidx_next;
    logic [1:0] t_reg, t_next;
    logic [1:0] j_reg, j_next;
    logic [1:0] i_reg, i_next;
    logic [1:0] rcnt_reg, rcnt_next;

    logic [1:0] r, c;
    logic [1:0] rs0, rs1, rs2;
    logic [1:0] cs0, cs1, cs2;
    logic [1:0] col_p, col_q, col_a;

    // rows and columns left in the minor of the current cofactor
    assign r     = cidx_reg[3:2];
    assign c     = cidx_reg[1:0];
    assign rs0   = mi4_keep(2'd0, r);
    assign rs1   = mi4_keep(2'd1, r);
    assign rs2   = mi4_keep(2'd2, r);
    assign cs0   = mi4_keep(2'd0, c);
    assign cs1   = mi4_keep(2'd1, c);
    assign cs2   = mi4_keep(2'd2, c);
    assign col_p = (t_reg == 2'd0) ? cs1 : cs0;
    assign col_q = (t_reg == 2'd2) ? cs1 : cs2;
    assign col_a = (t_reg == 2'd0) ? cs0 : ((t_reg == 2'd1) ? cs1 : cs2);

    // state and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cidx_reg  <= '0;
            t_reg     <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
            rcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cidx_reg  <= cidx_next;
            t_reg     <= t_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
            rcnt_reg  <= rcnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cidx_next  = cidx_reg;
        t_next     = t_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        rcnt_next  = rcnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.wr_row = 1'b1;
                    cmd.wr_idx = rcnt_reg;
                    rcnt_next  = 2'(rcnt_reg + 2'd1);
                    if (rcnt_reg == 2'd3)
                    begin
                        cidx_next  = '0;
                        state_next = ST_CLR_C;
                    end
                end
            end
            ST_CLR_C:
            begin
                cmd.clr_c  = 1'b1;
                t_next     = '0;
                state_next = ST_CLR_M;
            end
            ST_CLR_M:
            begin
                cmd.clr_m  = 1'b1;
                state_next = ST_M1_X;
            end
            ST_M1_X:
            begin
                cmd.ld_x_mat = 1'b1;
                cmd.mat_addr = {rs1, col_p};
                state_next   = ST_M1_Y;
            end
            ST_M1_Y:
            begin
                cmd.ld_y     = 1'b1;
                cmd.mat_addr = {rs2, col_q};
                state_next   = ST_M1_MUL;
            end
            ST_M1_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = ST_M1_ACC;
                end
            end
            ST_M1_ACC:
            begin
                cmd.acc_m  = 1'b1;
                state_next = ST_M2_X;
            end
            ST_M2_X:
            begin
                cmd.ld_x_mat = 1'b1;
                cmd.mat_addr = {rs1, col_q};
                state_next   = ST_M2_Y;
            end
            ST_M2_Y:
            begin
                cmd.ld_y     = 1'b1;
                cmd.mat_addr = {rs2, col_p};
                state_next   = ST_M2_MUL;
            end
            ST_M2_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = ST_M2_ACC;
                end
            end
            ST_M2_ACC:
            begin
                cmd.acc_m   = 1'b1;
                cmd.acc_sub = 1'b1;
                state_next  = ST_T_X;
            end
            ST_T_X:
            begin
                cmd.ld_x_m = 1'b1;
                state_next = ST_T_Y;
            end
            ST_T_Y:
            begin
                cmd.ld_y     = 1'b1;
                cmd.mat_addr = {rs0, col_a};
                state_next   = ST_T_MUL;
            end
            ST_T_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = ST_T_ACC;
                end
            end
            ST_T_ACC:
            begin
                cmd.acc_c   = 1'b1;
                cmd.acc_sub = (t_reg == 2'd1);
                if (t_reg == 2'd2)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    t_next     = 2'(t_reg + 2'd1);
                    state_next = ST_CLR_M;
                end
            end
            ST_STORE:
            begin
                cmd.st_cof   = 1'b1;
                cmd.cof_addr = cidx_reg;
                cmd.st_neg   = r[0] ^ c[0];
                cidx_next    = 4'(cidx_reg + 4'd1);
                state_next   = (cidx_reg == 4'd15) ? ST_DET_CLR : ST_CLR_C;
            end
            ST_DET_CLR:
            begin
                cmd.clr_d  = 1'b1;
                j_next     = '0;
                state_next = ST_D_X;
            end
            ST_D_X:
            begin
                cmd.ld_x_cof = 1'b1;
                cmd.cof_addr = {2'd0, j_reg};
                state_next   = ST_D_Y;
            end
            ST_D_Y:
            begin
                cmd.ld_y     = 1'b1;
                cmd.mat_addr = {2'd0, j_reg};
                state_next   = ST_D_MUL;
            end
            ST_D_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = ST_D_ACC;
                end
            end
            ST_D_ACC:
            begin
                cmd.acc_d = 1'b1;
                j_next    = 2'(j_reg + 2'd1);
                if (j_reg == 2'd3)
                begin
                    i_next     = '0;
                    state_next = ST_DIV_LOAD;
                end
                else
                begin
                    state_next = ST_D_X;
                end
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                cmd.cof_addr = {j_reg, i_reg};
                state_next   = stat.singular ? ST_DIV_END : ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END:
            begin
                cmd.div_end = 1'b1;
                cmd.out_col = j_reg;
                j_next      = 2'(j_reg + 2'd1);
                state_next  = (j_reg == 2'd3) ? ST_EMIT : ST_DIV_LOAD;
            end
            ST_EMIT:
            begin
                cmd.emit    = 1'b1;
                cmd.out_row = i_reg;
                i_next      = 2'(i_reg + 2'd1);
                state_next  = (i_reg == 2'd3) ? ST_IDLE : ST_DIV_LOAD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> sv/matrix_inverse_4x4_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_top: 4x4 inverse by cofactors and adjugate
// Signed Q16.16 in, rounded and saturated Q16.16 out.
// ----------------------------------------------------------------------------
// Usage
//   Input: a matrix is sent as four row items, row 0 first. An item is
//   taken when start is high while busy is low. Rows 0 to 2 each give no
//   result.
//   Output: after row 3 the block stays busy while it forms the sixteen
//   cofactors (nine serial 32-step multiplies each), the determinant and
//   sixteen 34-step divisions; a singular matrix skips the division steps.
//   The four inverse rows appear with valid high for one cycle each, row 0
//   first, the last with last_row set; a singular matrix gives zero rows
//   flagged singular. A new matrix is taken only once the last one is
//   through, the pace being set by the single shift-add multiplier and the
//   single restoring divider.
//   The receiver cannot stall: each result is valid for exactly one cycle.
//   Reset returns the sequencer to idle and the row count to zero.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4_top
    import mi4_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  mi4_in_t  item,
    output mi4_out_t result,
    output logic     valid
);

    mi4_cmd_t  cmd;
    mi4_stat_t stat;

    // sequencer
    mi4_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // arithmetic and storage
    mi4_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .valid  (valid)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 4x4 matrix inverse
// Drives row items through the start/busy handshake, predicts every inverse
// row with exact wide integer arithmetic and checks each strobed result.
// ----------------------------------------------------------------------------
module tb_top;
    import mi4_pkg::*;

    typedef logic signed [255:0] wide_t;
    typedef enum int {CHK_MODEL, CHK_IDENT, CHK_SING} chk_t;
    typedef struct {
        mi4_in_t row;
        chk_t    chk;
    } stim_t;

    localparam logic [31:0] ONE      = 32'h0001_0000;
    localparam logic [31:0] NEG_ONE  = 32'hFFFF_0000;
    localparam int          LIMIT    = 2000000;
    localparam int          N_RANDOM = 100;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    mi4_in_t  item;
    mi4_out_t result;
    logic     valid;

    logic signed [31:0] mat_copy [16];
    int                 rows_held;
    mi4_out_t           inv_rows_q [$];
    int                 mismatches;
    int                 cycles;
    int                 send_idle_pct;
    stim_t              dir_tab [$];

    matrix_inverse_4x4_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .result (result),
        .valid  (valid)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // signed cofactor of element (r, c) from the held matrix
    function automatic wide_t cofactor(int r, int c);
        int    rs [3];
        int    cs [3];
        int    n;
        wide_t e [3][3];
        wide_t d;
        n = 0;
        for (int i = 0; i < 4; i++) if (i != r) begin rs[n] = i; n++; end
        n = 0;
        for (int i = 0; i < 4; i++) if (i != c) begin cs[n] = i; n++; end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                e[i][j] = wide_t'(mat_copy[rs[i] * 4 + cs[j]]);
        d = e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
          - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
          + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
        return ((r + c) % 2 == 1) ? -d : d;
    endfunction

    // rounded (ties away from zero), saturated cof * 2^32 / det
    function automatic logic [31:0] scaled_div(wide_t num, wide_t det, inout bit clip);
        bit    neg;
        wide_t n;
        wide_t d;
        wide_t q;
        neg = (num < 0) != (det < 0);
        n = (num < 0) ? -num : num;
        d = (det < 0) ? -det : det;
        q = ((n <<< (2 * FRAC_BITS + 1)) + d) / (d <<< 1);
        if (neg)
        begin
            if (q > wide_t'(64'h8000_0000))
            begin
                clip = 1'b1;
                return SAT_MIN;
            end
            return 32'(-q);
        end
        if (q > wide_t'(64'h7FFF_FFFF))
        begin
            clip = 1'b1;
            return SAT_MAX;
        end
        return 32'(q);
    endfunction

    // store a row; on the fourth row queue the four inverse rows
    task automatic take_row(mi4_in_t r, chk_t chk);
        wide_t    cof [4][4];
        wide_t    det;
        mi4_out_t o;
        bit       clip;
        logic [31:0] v [4];
        mat_copy[rows_held * 4 + 0] = r.elem0;
        mat_copy[rows_held * 4 + 1] = r.elem1;
        mat_copy[rows_held * 4 + 2] = r.elem2;
        mat_copy[rows_held * 4 + 3] = r.elem3;
        if (rows_held < 3)
        begin
            rows_held++;
            return;
        end
        rows_held = 0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                cof[i][j] = cofactor(i, j);
        det = '0;
        for (int j = 0; j < 4; j++)
            det = det + wide_t'(mat_copy[j]) * cof[0][j];
        for (int i = 0; i < 4; i++)
        begin
            clip = 1'b0;
            for (int j = 0; j < 4; j++)
            begin
                if (chk == CHK_IDENT)
                    v[j] = (i == j) ? ONE : '0;
                else if (chk == CHK_SING || det == 0)
                    v[j] = '0;
                else
                    v[j] = scaled_div(cof[j][i], det, clip);
            end
            o.row_number = 2'(i);
            o.out0       = v[0];
            o.out1       = v[1];
            o.out2       = v[2];
            o.out3       = v[3];
            o.singular   = (chk == CHK_SING) || (chk == CHK_MODEL && det == 0);
            o.saturated  = clip;
            o.last_row   = (i == 3);
            inv_rows_q.push_back(o);
        end
    endtask

    // present one item and wait for it to be taken
    task automatic send_row(mi4_in_t r, chk_t chk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        take_row(r, chk);
    endtask

    // random element with a bias towards small and boundary values
    function automatic logic [31:0] rand_elem();
        int k;
        k = $urandom_range(9);
        if (k <= 5)
            return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
        if (k <= 7)
            return $urandom;
        if (k == 8)
        begin
            case ($urandom_range(4))
                0: return SAT_MAX;
                1: return SAT_MIN;
                2: return 32'd1;
                3: return 32'hFFFF_FFFF;
                default: return '0;
            endcase
        end
        return 32'($urandom_range(0, 8)) * ONE - 32'd4 * ONE;
    endfunction

    function automatic mi4_in_t mk(logic [31:0] a, logic [31:0] b,
                                   logic [31:0] c, logic [31:0] d);
        mi4_in_t r;
        r.elem0 = a;
        r.elem1 = b;
        r.elem2 = c;
        r.elem3 = d;
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            if (inv_rows_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result row %0d", result.row_number);
            end
            else
            begin
                mi4_out_t e;
                e = inv_rows_q.pop_front();
                if (result.row_number !== e.row_number || result.out0 !== e.out0 ||
                    result.out1 !== e.out1 || result.out2 !== e.out2 ||
                    result.out3 !== e.out3 || result.singular !== e.singular ||
                    result.saturated !== e.saturated || result.last_row !== e.last_row)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp r%0d %h %h %h %h s%b c%b l%b got r%0d %h %h %h %h s%b c%b l%b",
                            e.row_number, e.out0, e.out1, e.out2, e.out3,
                            e.singular, e.saturated, e.last_row,
                            result.row_number, result.out0, result.out1, result.out2,
                            result.out3, result.singular, result.saturated, result.last_row);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        mi4_in_t r;
        mi4_in_t keep_row;
        bit      dup;
        int      waited;
        cycles        = 0;
        mismatches    = 0;
        rows_held     = 0;
        send_idle_pct = 6;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        for (int i = 0; i < 16; i++) mat_copy[i] = '0;

        // identity
        dir_tab.push_back('{mk(ONE, 0, 0, 0), CHK_IDENT});
        dir_tab.push_back('{mk(0, ONE, 0, 0), CHK_IDENT});
        dir_tab.push_back('{mk(0, 0, ONE, 0), CHK_IDENT});
        dir_tab.push_back('{mk(0, 0, 0, ONE), CHK_IDENT});
        // zero matrix is singular
        for (int i = 0; i < 4; i++) dir_tab.push_back('{mk(0, 0, 0, 0), CHK_SING});
        // all positive full scale: singular
        for (int i = 0; i < 4; i++)
            dir_tab.push_back('{mk(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), CHK_SING});
        // smallest step of either sign on the diagonal: inverse clips high and low
        dir_tab.push_back('{mk(1, 0, 0, 0), CHK_MODEL});
        dir_tab.push_back('{mk(0, 1, 0, 0), CHK_MODEL});
        dir_tab.push_back('{mk(0, 0, 32'hFFFF_FFFF, 0), CHK_MODEL});
        dir_tab.push_back('{mk(0, 0, 0, 1), CHK_MODEL});
        // most negative on the diagonal, positive full scale in the last row
        dir_tab.push_back('{mk(SAT_MIN, 0, 0, 0), CHK_MODEL});
        dir_tab.push_back('{mk(0, SAT_MIN, 0, 0), CHK_MODEL});
        dir_tab.push_back('{mk(0, 0, SAT_MIN, 0), CHK_MODEL});
        dir_tab.push_back('{mk(0, 0, 0, SAT_MAX), CHK_MODEL});
        // mixed extremes
        dir_tab.push_back('{mk(SAT_MAX, SAT_MIN, 0, NEG_ONE), CHK_MODEL});
        dir_tab.push_back('{mk(SAT_MIN, SAT_MAX, ONE, 0), CHK_MODEL});
        dir_tab.push_back('{mk(0, NEG_ONE, SAT_MAX, SAT_MIN), CHK_MODEL});
        dir_tab.push_back('{mk(ONE, 0, SAT_MIN, 32'hFFFF_FFFF), CHK_MODEL});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_tab[i])
            send_row(dir_tab[i].row, dir_tab[i].chk);

        // random matrices, idling profile changes by thirds
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 4 == 0)
                dup = ($urandom_range(9) == 0);
            send_idle_pct = (n < N_RANDOM / 3) ? 6 : (n < 2 * N_RANDOM / 3) ? 65 : 0;
            r = mk(rand_elem(), rand_elem(), rand_elem(), rand_elem());
            if (n % 4 == 1)
                keep_row = r;
            // repeated row forces a singular matrix
            if (n % 4 == 3 && dup)
                r = keep_row;
            send_row(r, CHK_MODEL);
        end
        start <= 1'b0;

        // drain
        waited = 0;
        while (inv_rows_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);
        if (mismatches == 0 && inv_rows_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
